@@ rtl/cte_pkg.sv @@
// Package for the capability table engine.
// Holds operation and status codes, field widths and the entry, result and
// write-request types. Depends on nothing.
`default_nettype none

package cte_pkg;

	localparam int OP_W = 2;
	localparam int IDX_W = 8;
	localparam int WORD_W = 32;
	localparam int RIGHTS_W = 3;
	localparam int STATUS_W = 3;
	localparam int NEW_IDX_W = 6;

	localparam int IN_TDATA_W = 80;
	localparam int OUT_TDATA_W = 16;

	localparam logic [OP_W-1:0] OP_CREATE = 2'd0;
	localparam logic [OP_W-1:0] OP_GRANT = 2'd1;
	localparam logic [OP_W-1:0] OP_REVOKE = 2'd2;
	localparam logic [OP_W-1:0] OP_CHECK = 2'd3;

	localparam logic [STATUS_W-1:0] ST_OK = 3'd0;
	localparam logic [STATUS_W-1:0] ST_FULL = 3'd1;
	localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 3'd2;
	localparam logic [STATUS_W-1:0] ST_INVALID = 3'd3;
	localparam logic [STATUS_W-1:0] ST_NO_GRANT = 3'd4;

	localparam int RIGHT_GRANT_BIT = 2;

	typedef struct packed {
		logic signed [WORD_W-1:0] obj_ref;
		logic signed [WORD_W-1:0] badge;
		logic [RIGHTS_W-1:0] rights;
		logic valid;
	} cte_entry_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [NEW_IDX_W-1:0] new_index;
		logic allowed;
	} cte_result_t;

	typedef struct packed {
		logic en;
		logic append;
		cte_entry_t data;
	} cte_wreq_t;

endpackage

`default_nettype wire

@@ rtl/cte_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// The read register updates only when a read is enabled. No dependencies.
`default_nettype none

module cte_ram #(
	parameter int WIDTH = 68,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input wire logic clk,
	input wire logic wr_en,
	input wire logic [AW-1:0] wr_addr,
	input wire logic [WIDTH-1:0] wr_data,
	input wire logic rd_en,
	input wire logic [AW-1:0] rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

@@ rtl/cte_exec.sv @@
// Decision logic for one capability operation: status, result fields and
// the table write, if any, that it causes. Uses cte_pkg types and codes.
`default_nettype none

module cte_exec #(
	parameter int TABLE_DEPTH = 64,
	localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
	input wire logic [cte_pkg::OP_W-1:0] operation,
	input wire logic [cte_pkg::IDX_W-1:0] cap_index,
	input wire logic signed [cte_pkg::WORD_W-1:0] obj_ref,
	input wire logic [cte_pkg::RIGHTS_W-1:0] rights,
	input wire logic signed [cte_pkg::WORD_W-1:0] badge,
	input wire logic [CW-1:0] fill_count,
	input wire cte_pkg::cte_entry_t entry,
	output cte_pkg::cte_result_t result,
	output cte_pkg::cte_wreq_t wreq
);

	logic full;
	logic bad_index;
	logic [CW+cte_pkg::NEW_IDX_W-1:0] fill_ext;

	assign full = (fill_count == CW'(TABLE_DEPTH));
	assign bad_index = {{CW{1'b0}}, cap_index} >= {{cte_pkg::IDX_W{1'b0}}, fill_count};
	assign fill_ext = {{cte_pkg::NEW_IDX_W{1'b0}}, fill_count};

	always_comb begin
		result.status = cte_pkg::ST_OK;
		result.new_index = '0;
		result.allowed = 1'b0;
		wreq.en = 1'b0;
		wreq.append = 1'b0;
		wreq.data = entry;
		unique case (operation)
			cte_pkg::OP_CREATE: begin
				if (full) begin
					result.status = cte_pkg::ST_FULL;
				end else begin
					wreq.en = 1'b1;
					wreq.append = 1'b1;
					wreq.data.obj_ref = obj_ref;
					wreq.data.badge = badge;
					wreq.data.rights = rights;
					wreq.data.valid = 1'b1;
					result.new_index = fill_ext[cte_pkg::NEW_IDX_W-1:0];
				end
			end
			cte_pkg::OP_GRANT: begin
				if (bad_index) begin
					result.status = cte_pkg::ST_BAD_INDEX;
				end else if (!entry.valid) begin
					result.status = cte_pkg::ST_INVALID;
				end else if (!entry.rights[cte_pkg::RIGHT_GRANT_BIT]) begin
					result.status = cte_pkg::ST_NO_GRANT;
				end else if (full) begin
					result.status = cte_pkg::ST_FULL;
				end else begin
					wreq.en = 1'b1;
					wreq.append = 1'b1;
					wreq.data.rights = entry.rights & rights;
					wreq.data.valid = 1'b1;
					result.new_index = fill_ext[cte_pkg::NEW_IDX_W-1:0];
				end
			end
			cte_pkg::OP_REVOKE: begin
				if (bad_index) begin
					result.status = cte_pkg::ST_BAD_INDEX;
				end else begin
					wreq.en = 1'b1;
					wreq.data.badge = '0;
					wreq.data.rights = '0;
					wreq.data.valid = 1'b0;
				end
			end
			cte_pkg::OP_CHECK: begin
				if (bad_index) begin
					result.status = cte_pkg::ST_BAD_INDEX;
				end else if (!entry.valid) begin
					result.status = cte_pkg::ST_INVALID;
				end else begin
					result.allowed = |(entry.rights & rights);
				end
			end
			default: begin
				result.status = cte_pkg::ST_OK;
			end
		endcase
	end

endmodule

`default_nettype wire

@@ rtl/capability_table_engine.sv @@
// Capability table engine, top level. Accepted items are registered in stage
// one and their results in the output register. Throughput: one item per
// cycle while the output does not stall, set by the table RAM read at acceptance
// plus forwarding of the write made by the item ahead. Reset clears the fill
// count and pipeline valid flags; the table RAM is not swept, since only
// entries below the fill count are used. Uses cte_pkg, cte_ram and cte_exec.
`default_nettype none

module capability_table_engine #(
	parameter int TABLE_DEPTH = 64
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_axis_tvalid,
	output logic s_axis_tready,
	// operation[1:0], cap_index[9:2], obj_ref[41:10], rights[44:42],
	// badge[76:45], zero fill above.
	input wire logic [cte_pkg::IN_TDATA_W-1:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input wire logic m_axis_tready,
	// status[2:0], new_index[8:3], allowed[9], zero fill above.
	output logic [cte_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int EW = $bits(cte_pkg::cte_entry_t);
	localparam int RW = $bits(cte_pkg::cte_result_t);

	logic valid_s1;
	logic [cte_pkg::OP_W-1:0] operation_s1;
	logic [cte_pkg::IDX_W-1:0] cap_index_s1;
	logic signed [cte_pkg::WORD_W-1:0] obj_ref_s1;
	logic [cte_pkg::RIGHTS_W-1:0] rights_s1;
	logic signed [cte_pkg::WORD_W-1:0] badge_s1;
	logic fwd_hit_s1;
	cte_pkg::cte_entry_t fwd_entry_s1;

	logic [CW-1:0] fill_q;
	logic out_valid_q;
	cte_pkg::cte_result_t out_q;

	logic accept;
	logic fire;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] wr_addr;
	logic [EW-1:0] ram_rd;
	cte_pkg::cte_entry_t entry;
	cte_pkg::cte_result_t result;
	cte_pkg::cte_wreq_t wreq;
	logic wr_now;

	assign fire = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || fire;
	assign accept = s_axis_tvalid && s_axis_tready;
	assign wr_now = fire && wreq.en;

	assign rd_addr = s_axis_tdata[2 +: AW];
	assign wr_addr = wreq.append ? fill_q[AW-1:0] : cap_index_s1[AW-1:0];

	cte_ram #(
		.WIDTH(EW),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk(clk),
		.wr_en(wr_now),
		.wr_addr(wr_addr),
		.wr_data(wreq.data),
		.rd_en(accept),
		.rd_addr(rd_addr),
		.rd_data(ram_rd)
	);

	assign entry = fwd_hit_s1 ? fwd_entry_s1 : cte_pkg::cte_entry_t'(ram_rd);

	cte_exec #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_exec (
		.operation(operation_s1),
		.cap_index(cap_index_s1),
		.obj_ref(obj_ref_s1),
		.rights(rights_s1),
		.badge(badge_s1),
		.fill_count(fill_q),
		.entry(entry),
		.result(result),
		.wreq(wreq)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			fwd_hit_s1 <= 1'b0;
			fill_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
				fwd_hit_s1 <= wr_now && (wr_addr == rd_addr);
			end else if (fire) begin
				valid_s1 <= 1'b0;
			end
			if (wr_now && wreq.append) begin
				fill_q <= fill_q + CW'(1);
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			operation_s1 <= s_axis_tdata[1:0];
			cap_index_s1 <= s_axis_tdata[9:2];
			obj_ref_s1 <= s_axis_tdata[41:10];
			rights_s1 <= s_axis_tdata[44:42];
			badge_s1 <= s_axis_tdata[76:45];
			fwd_entry_s1 <= wreq.data;
		end
		if (fire) begin
			out_q <= result;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {{(cte_pkg::OUT_TDATA_W - RW){1'b0}}, out_q.allowed,
		out_q.new_index, out_q.status};

	assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(TABLE_DEPTH))
		else $error("fill count beyond table depth");

	assert property (@(posedge clk) disable iff (!arst_n)
		fire && result.status == cte_pkg::ST_OK
			&& (operation_s1 == cte_pkg::OP_CREATE || operation_s1 == cte_pkg::OP_GRANT)
		|=> fill_q == $past(fill_q) + CW'(1))
		else $error("successful append did not advance fill count");

	assert property (@(posedge clk) disable iff (!arst_n)
		fire && result.status != cte_pkg::ST_OK |=> fill_q == $past(fill_q))
		else $error("failed operation changed fill count");

	assert property (@(posedge clk) disable iff (!arst_n)
		fire && result.allowed |-> result.status == cte_pkg::ST_OK
			&& operation_s1 == cte_pkg::OP_CHECK)
		else $error("allowed set outside a successful check");

	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !fire |=> valid_s1 && $stable(operation_s1) && $stable(cap_index_s1))
		else $error("stalled item in stage one was lost or overwritten");

endmodule

`default_nettype wire

@@ tb/sv/cap_table_checker.sv @@
// Checker for the capability table engine: watches both stream channels,
// predicts each result from its own copy of the table and compares field by field.
// Depends on cte_pkg for codes, widths and the entry and result types.
`timescale 1ns / 100ps
`default_nettype none

module cap_table_checker #(
	parameter int DEPTH = 64
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	input wire logic s_tready,
	input wire logic [cte_pkg::IN_TDATA_W-1:0] s_tdata,
	input wire logic m_tvalid,
	input wire logic m_tready,
	input wire logic [cte_pkg::OUT_TDATA_W-1:0] m_tdata,
	output int error_count,
	output int outstanding,
	output int fill_level
);

	cte_pkg::cte_entry_t cap_table [DEPTH];
	int unsigned fill;
	cte_pkg::cte_result_t due_results [$];
	cte_pkg::cte_result_t want;
	int taken_in;
	int taken_out;

	assign outstanding = taken_in - taken_out;

	task automatic report_mismatch(input string field, input int got, input int want_val);
		$display("%0t checker: result %0d %s: got %0d, expected %0d",
			$time, taken_out, field, got, want_val);
		error_count++;
	endtask

	function automatic cte_pkg::cte_result_t apply_cap_op(
		input logic [cte_pkg::OP_W-1:0] op,
		input logic [cte_pkg::IDX_W-1:0] idx,
		input logic signed [cte_pkg::WORD_W-1:0] obj,
		input logic [cte_pkg::RIGHTS_W-1:0] rts,
		input logic signed [cte_pkg::WORD_W-1:0] bdg);
		cte_pkg::cte_result_t r;
		r = '0;
		r.status = cte_pkg::ST_OK;
		if (op == cte_pkg::OP_CREATE) begin
			if (fill >= DEPTH) begin
				r.status = cte_pkg::ST_FULL;
			end else begin
				cap_table[fill] = '{obj_ref: obj, badge: bdg, rights: rts, valid: 1'b1};
				r.new_index = cte_pkg::NEW_IDX_W'(fill);
				fill++;
			end
		end else if (idx >= fill) begin
			r.status = cte_pkg::ST_BAD_INDEX;
		end else if (op == cte_pkg::OP_REVOKE) begin
			cap_table[idx].rights = '0;
			cap_table[idx].badge = '0;
			cap_table[idx].valid = 1'b0;
		end else if (!cap_table[idx].valid) begin
			r.status = cte_pkg::ST_INVALID;
		end else if (op == cte_pkg::OP_GRANT) begin
			if (!cap_table[idx].rights[cte_pkg::RIGHT_GRANT_BIT]) begin
				r.status = cte_pkg::ST_NO_GRANT;
			end else if (fill >= DEPTH) begin
				r.status = cte_pkg::ST_FULL;
			end else begin
				cap_table[fill] = '{obj_ref: cap_table[idx].obj_ref,
					badge: cap_table[idx].badge,
					rights: cap_table[idx].rights & rts, valid: 1'b1};
				r.new_index = cte_pkg::NEW_IDX_W'(fill);
				fill++;
			end
		end else begin
			r.allowed = |(cap_table[idx].rights & rts);
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DEPTH; k++) begin
				cap_table[k] = '{obj_ref: -1, badge: '0, rights: '0, valid: 1'b0};
			end
			fill = 0;
			due_results.delete();
			error_count = 0;
			taken_in <= 0;
			taken_out <= 0;
			fill_level <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (due_results.size() == 0) begin
					report_mismatch("unexpected item, status", int'(m_tdata[2:0]), -1);
				end else begin
					want = due_results.pop_front();
					if (m_tdata[2:0] !== want.status) begin
						report_mismatch("status", int'(m_tdata[2:0]), int'(want.status));
					end
					if (m_tdata[8:3] !== want.new_index) begin
						report_mismatch("new_index", int'(m_tdata[8:3]),
							int'(want.new_index));
					end
					if (m_tdata[9] !== want.allowed) begin
						report_mismatch("allowed", int'(m_tdata[9]), int'(want.allowed));
					end
				end
				taken_out <= taken_out + 1;
			end
			if (s_tvalid && s_tready) begin
				due_results.push_back(apply_cap_op(s_tdata[1:0], s_tdata[9:2],
					s_tdata[41:10], s_tdata[44:42], s_tdata[76:45]));
				taken_in <= taken_in + 1;
			end
			fill_level <= fill;
		end
	end

endmodule

`default_nettype wire

@@ tb/sv/tb_capability_table_engine.sv @@
// Top of the capability table engine testbench: clock, reset, stimulus and verdict.
// Instantiates capability_table_engine and cap_table_checker; uses cte_pkg codes.
`timescale 1ns / 100ps
`default_nettype none

module tb_capability_table_engine;

	localparam int DEPTH = 64;
	localparam int IDLE_LIMIT = 2000;
	localparam int RANDOM_ITEMS = 780;
	localparam int HOLD_CYCLES = 100;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [cte_pkg::IN_TDATA_W-1:0] s_axis_tdata;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [cte_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
	int error_count;
	int outstanding;
	int fill_level;
	logic hold_rx;
	logic no_gaps;

	capability_table_engine #(
		.TABLE_DEPTH(DEPTH)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	cap_table_checker #(
		.DEPTH(DEPTH)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_axis_tvalid),
		.s_tready(s_axis_tready),
		.s_tdata(s_axis_tdata),
		.m_tvalid(m_axis_tvalid),
		.m_tready(m_axis_tready),
		.m_tdata(m_axis_tdata),
		.error_count(error_count),
		.outstanding(outstanding),
		.fill_level(fill_level)
	);

	function automatic logic [cte_pkg::IN_TDATA_W-1:0] pack_cmd(
		input logic [cte_pkg::OP_W-1:0] op,
		input logic [cte_pkg::IDX_W-1:0] idx, input logic [cte_pkg::WORD_W-1:0] obj,
		input logic [cte_pkg::RIGHTS_W-1:0] rts, input logic [cte_pkg::WORD_W-1:0] bdg);
		logic [cte_pkg::IN_TDATA_W-1:0] d;
		d = '0;
		d[76:0] = {bdg, rts, obj, idx, op};
		return d;
	endfunction

	task automatic send_cmd(input logic [cte_pkg::OP_W-1:0] op,
		input logic [cte_pkg::IDX_W-1:0] idx,
		input logic [cte_pkg::WORD_W-1:0] obj, input logic [cte_pkg::RIGHTS_W-1:0] rts,
		input logic [cte_pkg::WORD_W-1:0] bdg);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tdata <= pack_cmd(op, idx, obj, rts, bdg);
		s_axis_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	// Most indices land below the fill count; some sit at or just past it, or anywhere.
	task automatic random_cmd();
		int r;
		logic [cte_pkg::OP_W-1:0] op;
		logic [cte_pkg::IDX_W-1:0] idx;
		r = $urandom_range(0, 99);
		if (r < 9) begin
			op = cte_pkg::OP_CREATE;
		end else if (r < 24) begin
			op = cte_pkg::OP_GRANT;
		end else if (r < 34) begin
			op = cte_pkg::OP_REVOKE;
		end else begin
			op = cte_pkg::OP_CHECK;
		end
		r = $urandom_range(0, 99);
		if (fill_level > 0 && r < 85) begin
			idx = cte_pkg::IDX_W'($urandom_range(0, fill_level - 1));
		end else if (r < 95) begin
			idx = cte_pkg::IDX_W'(fill_level + $urandom_range(0, 2));
		end else begin
			idx = cte_pkg::IDX_W'($urandom_range(0, 255));
		end
		send_cmd(op, idx, $urandom(), cte_pkg::RIGHTS_W'($urandom_range(0, 7)), $urandom());
	endtask

	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// A change of hold_rx asks the receiver for one long hold-off.
	initial begin
		int gap;
		logic hold_seen;
		hold_seen = 1'b0;
		m_axis_tready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_rx !== hold_seen) begin
				hold_seen = hold_rx;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			gap = no_gaps ? 0 : $urandom_range(0, 13);
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid) @(posedge clk);
		end
	end

	initial begin
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
				idle = 0;
			end else begin
				idle++;
			end
		end
		$display("tb: failure");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		hold_rx = 1'b0;
		no_gaps = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_cmd(cte_pkg::OP_CHECK, 8'd0, $urandom(), 3'd7, $urandom());
		send_cmd(cte_pkg::OP_GRANT, 8'd0, $urandom(), 3'd7, $urandom());
		send_cmd(cte_pkg::OP_REVOKE, 8'd255, $urandom(), 3'd7, $urandom());
		send_cmd(cte_pkg::OP_CREATE, 8'd0, 32'h7fff_ffff, 3'd7, 32'h8000_0000);
		send_cmd(cte_pkg::OP_CREATE, 8'd255, 32'h8000_0000, 3'd3, 32'hffff_ffff);
		send_cmd(cte_pkg::OP_CREATE, 8'd0, 32'h0000_0000, 3'd0, 32'h0000_0000);
		send_cmd(cte_pkg::OP_GRANT, 8'd0, $urandom(), 3'd3, $urandom());
		send_cmd(cte_pkg::OP_GRANT, 8'd0, $urandom(), 3'd7, $urandom());
		send_cmd(cte_pkg::OP_GRANT, 8'd1, $urandom(), 3'd7, $urandom());
		send_cmd(cte_pkg::OP_CHECK, 8'd0, $urandom(), 3'd4, $urandom());
		send_cmd(cte_pkg::OP_CHECK, 8'd2, $urandom(), 3'd7, $urandom());
		send_cmd(cte_pkg::OP_CHECK, 8'd0, $urandom(), 3'd0, $urandom());
		send_cmd(cte_pkg::OP_CHECK, 8'd5, $urandom(), 3'd7, $urandom());
		send_cmd(cte_pkg::OP_CHECK, 8'd255, $urandom(), 3'd7, $urandom());
		send_cmd(cte_pkg::OP_REVOKE, 8'd0, $urandom(), 3'd7, $urandom());
		send_cmd(cte_pkg::OP_REVOKE, 8'd0, $urandom(), 3'd0, $urandom());
		send_cmd(cte_pkg::OP_CHECK, 8'd0, $urandom(), 3'd7, $urandom());
		send_cmd(cte_pkg::OP_GRANT, 8'd0, $urandom(), 3'd7, $urandom());
		send_cmd(cte_pkg::OP_GRANT, 8'd4, $urandom(), 3'd4, $urandom());
		send_cmd(cte_pkg::OP_CHECK, 8'd3, $urandom(), 3'd1, $urandom());
		send_cmd(cte_pkg::OP_GRANT, 8'd3, $urandom(), 3'd7, $urandom());
		send_cmd(cte_pkg::OP_REVOKE, 8'd2, $urandom(), 3'd5, $urandom());
		send_cmd(cte_pkg::OP_CHECK, 8'd2, $urandom(), 3'd2, $urandom());

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == 150 || n == 560) begin
				hold_rx = !hold_rx;
			end
			if (n == 300) begin
				drain_results();
			end
			no_gaps = (n >= 400 && n < 470) || (n >= 650 && n < 700);
			random_cmd();
		end

		drain_results();
		repeat (4) @(posedge clk);
		if (error_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

`default_nettype wire
